// File: hw/rtl/vga_vbe_port_register_file_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker of the VGA/VBE port register file.
// ---------------------------------------------------------------------------
`ifndef VGA_VBE_PORT_REGISTER_FILE_ASSERT_SVH
`define VGA_VBE_PORT_REGISTER_FILE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define VVPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("port register file check failed");

// The consequent holds in the cycle after the antecedent.
`define VVPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port register file check failed");

`endif

// File: hw/rtl/vvpr_pkg.sv
// ---------------------------------------------------------------------------
// vvpr_pkg
// Types and constants of the VGA/VBE port register file.
// ---------------------------------------------------------------------------
package vvpr_pkg;

    localparam int PORT_W = 10;
    localparam int DATA_W = 16;
    localparam int BYTE_W = 8;

    // Port numbers.
    localparam logic [PORT_W-1:0] PORT_ATTR      = 10'h3C0;
    localparam logic [PORT_W-1:0] PORT_MISC_WR   = 10'h3C2;
    localparam logic [PORT_W-1:0] PORT_SEQ_IDX   = 10'h3C4;
    localparam logic [PORT_W-1:0] PORT_PEL_MASK  = 10'h3C6;
    localparam logic [PORT_W-1:0] PORT_PAL_WIDX  = 10'h3C8;
    localparam logic [PORT_W-1:0] PORT_PAL_DATA  = 10'h3C9;
    localparam logic [PORT_W-1:0] PORT_MISC_RD   = 10'h3CC;
    localparam logic [PORT_W-1:0] PORT_GFX_IDX   = 10'h3CE;
    localparam logic [PORT_W-1:0] PORT_CRTC_IDX  = 10'h3D4;
    localparam logic [PORT_W-1:0] PORT_STATUS1   = 10'h3DA;
    localparam logic [PORT_W-1:0] PORT_VBE_INDEX = 10'h1CE;
    localparam logic [PORT_W-1:0] PORT_VBE_DATA  = 10'h1CF;

    localparam logic [BYTE_W-1:0] MISC_WR_MASK  = 8'hEF;
    localparam logic [BYTE_W-1:0] PEL_MASK_FULL = 8'hFF;

    // VBE register indices.
    localparam logic [DATA_W-1:0] VBE_IDX_XRES   = 16'h0001;
    localparam logic [DATA_W-1:0] VBE_IDX_YRES   = 16'h0002;
    localparam logic [DATA_W-1:0] VBE_IDX_BPP    = 16'h0003;
    localparam logic [DATA_W-1:0] VBE_IDX_ENABLE = 16'h0004;
    localparam logic [DATA_W-1:0] VBE_IDX_VRAM   = 16'h000A;
    localparam int               VBE_GETCAPS_BIT = 1;

    // Configuration register indices.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_XRES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YRES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VRAM     = 2'd3;

    localparam logic [DATA_W-1:0] RST_MAX_XRES = 16'd16000;
    localparam logic [DATA_W-1:0] RST_MAX_YRES = 16'd12000;
    localparam logic [DATA_W-1:0] RST_MAX_BPP  = 16'd32;
    localparam logic [DATA_W-1:0] RST_VRAM     = 16'd1024;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNIMPL = 2'd1,
        ST_MASK   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Control of one VBE register file access.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } vbe_ctl_t;

    // Control of one palette access.
    typedef struct packed {
        logic set_ptr;
        logic wr_data;
    } pal_ctl_t;

endpackage

// File: hw/rtl/vga_vbe_port_register_file.sv
// ---------------------------------------------------------------------------
// vga_vbe_port_register_file
// Legacy VGA ports 0x3C0-0x3DF and the Bochs VBE index/data pair.
// ---------------------------------------------------------------------------
// An access is issued by raising start with func, port_address and
// write_data; it is taken at a rising edge where busy is low. Every access
// gives exactly one result: read_data and status are valid for the single
// cycle in which done is high, registered from the execute state of the access.
// read_data is zero for writes and for failed accesses.
// The block runs one access at a time: busy is high while the access is in
// its execute state, and no new access is taken while it is high. This limit is
// set by the registered read port of the VBE register memory, which is read
// at the transfer and written back in the execute cycle.
// The result side has no stall: done is a strobe and the receiver must take
// it. Configuration writes (cfg_write, cfg_index, cfg_data) land at the next
// edge and must be made while the block is idle; the block does not enforce it.
// Reset clears every index latch, the palette pointer, the retrace toggle,
// the VBE select and the VBE register file (through valid bits, so there is
// no clearing pass), and loads the default capability values.
// ---------------------------------------------------------------------------
module vga_vbe_port_register_file
    import vvpr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 768,
    parameter int VBE_REG_COUNT   = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [PORT_W-1:0]    port_address,
    input  logic [DATA_W-1:0]    write_data,
    output logic                 done,
    output logic [DATA_W-1:0]    read_data,
    output logic [1:0]           status,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int VIDX_W = $clog2(VBE_REG_COUNT);
    localparam logic [DATA_W-1:0] VBE_COUNT_W = DATA_W'(VBE_REG_COUNT);

    state_t            state_reg;
    state_t            state_next;

    logic              func_reg;
    logic [PORT_W-1:0] port_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic [DATA_W-1:0] max_xres_reg;
    logic [DATA_W-1:0] max_yres_reg;
    logic [DATA_W-1:0] max_bpp_reg;
    logic [DATA_W-1:0] vram_reg;

    logic [BYTE_W-1:0] attr_idx_reg;
    logic [BYTE_W-1:0] attr_idx_next;
    logic [BYTE_W-1:0] misc_reg;
    logic [BYTE_W-1:0] misc_next;
    logic [BYTE_W-1:0] seq_idx_reg;
    logic [BYTE_W-1:0] seq_idx_next;
    logic [BYTE_W-1:0] gfx_idx_reg;
    logic [BYTE_W-1:0] gfx_idx_next;
    logic [BYTE_W-1:0] crtc_idx_reg;
    logic [BYTE_W-1:0] crtc_idx_next;
    logic              retrace_reg;
    logic              retrace_next;
    logic [DATA_W-1:0] vbe_sel_reg;
    logic [DATA_W-1:0] vbe_sel_next;
    logic              getcaps_reg;
    logic              getcaps_next;

    logic              done_reg;
    logic              done_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] rdata_next;
    status_t           status_reg;
    status_t           status_next;

    logic              accept;
    logic              sel_in_range;
    logic [DATA_W-1:0] vbe_rd_data;
    logic [DATA_W-1:0] vbe_value;
    vbe_ctl_t          vbe_ctl;
    pal_ctl_t          pal_ctl;
    logic [BYTE_W-1:0] wbyte;

    assign accept       = start && (state_reg == S_IDLE);
    assign busy         = (state_reg != S_IDLE);
    assign sel_in_range = (vbe_sel_reg < VBE_COUNT_W);
    assign wbyte        = wdata_reg[BYTE_W-1:0];

    vvpr_vbe_ram #(
        .DEPTH (VBE_REG_COUNT)
    ) u_vbe_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (vbe_ctl),
        .rd_addr (vbe_sel_reg[VIDX_W-1:0]),
        .wr_addr (vbe_sel_reg[VIDX_W-1:0]),
        .wr_data (wdata_reg),
        .rd_data (vbe_rd_data)
    );

    vvpr_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (pal_ctl),
        .wr_byte (wbyte)
    );

    // Value seen on a read of the VBE data port.
    always_comb
    begin
        if (sel_in_range)
        begin
            if (getcaps_reg && (vbe_sel_reg == VBE_IDX_XRES))
            begin
                vbe_value = max_xres_reg;
            end
            else if (getcaps_reg && (vbe_sel_reg == VBE_IDX_YRES))
            begin
                vbe_value = max_yres_reg;
            end
            else if (getcaps_reg && (vbe_sel_reg == VBE_IDX_BPP))
            begin
                vbe_value = max_bpp_reg;
            end
            else
            begin
                vbe_value = vbe_rd_data;
            end
        end
        else if (vbe_sel_reg == VBE_IDX_VRAM)
        begin
            vbe_value = vram_reg;
        end
        else
        begin
            vbe_value = '0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        attr_idx_next = attr_idx_reg;
        misc_next     = misc_reg;
        seq_idx_next  = seq_idx_reg;
        gfx_idx_next  = gfx_idx_reg;
        crtc_idx_next = crtc_idx_reg;
        retrace_next  = retrace_reg;
        vbe_sel_next  = vbe_sel_reg;
        getcaps_next  = getcaps_reg;
        done_next     = 1'b0;
        rdata_next    = rdata_reg;
        status_next   = status_reg;
        vbe_ctl       = '0;
        pal_ctl       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // The select does not change before the execute cycle.
                    vbe_ctl.rd_en = sel_in_range;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                done_next   = 1'b1;
                rdata_next  = '0;
                status_next = ST_OK;
                state_next  = S_IDLE;
                if (func_reg == FUNC_READ)
                begin
                    unique case (port_reg)
                        PORT_ATTR:      rdata_next = DATA_W'(attr_idx_reg);
                        PORT_MISC_RD:   rdata_next = DATA_W'(misc_reg);
                        PORT_STATUS1:
                        begin
                            retrace_next = !retrace_reg;
                            rdata_next   = DATA_W'({!retrace_reg, 3'b000});
                        end
                        PORT_VBE_INDEX: rdata_next = vbe_sel_reg;
                        PORT_VBE_DATA:  rdata_next = vbe_value;
                        default:        status_next = ST_UNIMPL;
                    endcase
                end
                else
                begin
                    unique case (port_reg)
                        PORT_ATTR:     attr_idx_next = wbyte;
                        PORT_MISC_WR:  misc_next     = wbyte & MISC_WR_MASK;
                        PORT_SEQ_IDX:  seq_idx_next  = wbyte;
                        PORT_PEL_MASK:
                        begin
                            if (wbyte != PEL_MASK_FULL)
                            begin
                                status_next = ST_MASK;
                            end
                        end
                        PORT_PAL_WIDX: pal_ctl.set_ptr = 1'b1;
                        PORT_PAL_DATA: pal_ctl.wr_data = 1'b1;
                        PORT_GFX_IDX:  gfx_idx_next  = wbyte;
                        PORT_CRTC_IDX: crtc_idx_next = wbyte;
                        PORT_VBE_INDEX: vbe_sel_next = wdata_reg;
                        PORT_VBE_DATA:
                        begin
                            if (sel_in_range)
                            begin
                                vbe_ctl.wr_en = 1'b1;
                                // Shadow of the capability bit of ENABLE.
                                if (vbe_sel_reg == VBE_IDX_ENABLE)
                                begin
                                    getcaps_next = wdata_reg[VBE_GETCAPS_BIT];
                                end
                            end
                        end
                        default:       status_next = ST_UNIMPL;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            port_reg  <= port_address;
            wdata_reg <= write_data;
        end
        rdata_reg <= rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            attr_idx_reg <= '0;
            misc_reg     <= '0;
            seq_idx_reg  <= '0;
            gfx_idx_reg  <= '0;
            crtc_idx_reg <= '0;
            retrace_reg  <= 1'b0;
            vbe_sel_reg  <= '0;
            getcaps_reg  <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            attr_idx_reg <= attr_idx_next;
            misc_reg     <= misc_next;
            seq_idx_reg  <= seq_idx_next;
            gfx_idx_reg  <= gfx_idx_next;
            crtc_idx_reg <= crtc_idx_next;
            retrace_reg  <= retrace_next;
            vbe_sel_reg  <= vbe_sel_next;
            getcaps_reg  <= getcaps_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_xres_reg <= RST_MAX_XRES;
            max_yres_reg <= RST_MAX_YRES;
            max_bpp_reg  <= RST_MAX_BPP;
            vram_reg     <= RST_VRAM;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_XRES: max_xres_reg <= cfg_data;
                CFG_MAX_YRES: max_yres_reg <= cfg_data;
                CFG_MAX_BPP:  max_bpp_reg  <= cfg_data;
                CFG_VRAM:     vram_reg     <= cfg_data;
                default:      vram_reg     <= vram_reg;
            endcase
        end
    end

    assign done      = done_reg;
    assign read_data = rdata_reg;
    assign status    = status_reg;

endmodule

// File: hw/rtl/vvpr_vbe_ram.sv
// ---------------------------------------------------------------------------
// vvpr_vbe_ram
// VBE DISPI register file: a synchronous memory with per-entry valid bits so
// that entries not yet written read as zero after reset.
// ---------------------------------------------------------------------------
module vvpr_vbe_ram
    import vvpr_pkg::*;
#(
    parameter int DEPTH = 10,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vbe_ctl_t          ctl,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: hw/rtl/vvpr_palette.sv
// ---------------------------------------------------------------------------
// vvpr_palette
// DAC palette store with its auto-incrementing write pointer.
// ---------------------------------------------------------------------------
module vvpr_palette
    import vvpr_pkg::*;
#(
    parameter int ENTRIES = 768,
    parameter int PTR_W   = $clog2(ENTRIES)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  pal_ctl_t          ctl,
    input  logic [BYTE_W-1:0] wr_byte
);

    // Wide enough for a byte times three and for the entry count.
    localparam int WIDE_W = (PTR_W > BYTE_W + 2) ? PTR_W + 1 : BYTE_W + 2;
    localparam logic [WIDE_W-1:0] ENTRIES_W = WIDE_W'(ENTRIES);

    logic [BYTE_W-1:0] mem [ENTRIES];
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [WIDE_W-1:0] set_val;
    logic [WIDE_W-1:0] cur_wide;
    logic [WIDE_W-1:0] inc_wide;
    logic [PTR_W-1:0]  cur_ptr;

    always_comb
    begin
        set_val  = WIDE_W'(wr_byte) + WIDE_W'({wr_byte, 1'b0});
        cur_wide = WIDE_W'(ptr_reg);
        cur_ptr  = (cur_wide < ENTRIES_W) ? ptr_reg : '0;
        inc_wide = WIDE_W'(cur_ptr) + WIDE_W'(1);
        ptr_next = ptr_reg;
        if (ctl.set_ptr)
        begin
            ptr_next = (set_val < ENTRIES_W) ? set_val[PTR_W-1:0] : '0;
        end
        else if (ctl.wr_data)
        begin
            ptr_next = (inc_wide < ENTRIES_W) ? inc_wide[PTR_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_data)
        begin
            mem[cur_ptr] <= wr_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

endmodule

// File: hw/rtl/vvpr_checker.sv
// ---------------------------------------------------------------------------
// vvpr_checker
// Port-level checks of the VGA/VBE port register file, bound to the top.
// ---------------------------------------------------------------------------
`include "vga_vbe_port_register_file_assert.svh"

module vvpr_checker
    import vvpr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              func,
    input logic              done,
    input logic [DATA_W-1:0] read_data,
    input logic [1:0]        status
);

    // A transfer makes the block busy, and busy drops again as done is raised.
    `VVPR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `VVPR_ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy && done)

    // Each result follows its transfer through the execute state and the done register.
    `VVPR_ASSERT_SAME(a_done_after_accept, clk, rst_n, done,
                      $past(start && !busy, 2))

    // Writes never return data, and status stays within its three codes.
    `VVPR_ASSERT_SAME(a_write_no_data, clk, rst_n,
                      done && ($past(func, 2) == FUNC_WRITE), read_data == '0)
    `VVPR_ASSERT_SAME(a_status_code, clk, rst_n, done, status != 2'd3)

endmodule

bind vga_vbe_port_register_file vvpr_checker u_vvpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .done      (done),
    .read_data (read_data),
    .status    (status)
);
